// ===== src/cif_pkg.sv =====
package cif_pkg;

    localparam int NUM_TAPS   = 32;
    localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
    localparam int TAP_CNT_W  = TAP_IDX_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = COEF_W - 2;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    // 64 complex terms of at most 2^33 each, plus headroom
    localparam int ACC_W      = PROD_W + 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TAP_CNT_W;

    localparam logic [TAP_CNT_W-1:0] MAX_TAP_CNT = TAP_CNT_W'(NUM_TAPS);

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_FF_COEF = 2'd1,
        CMD_FB_COEF = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_TAPS = 1'b0,
        REG_FB_TAPS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_smp;

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
    } t_coef;

    typedef struct packed {
        logic clr;   // zero the accumulator
        logic en;    // operands valid this cycle
    } t_mac_ctl;

endpackage

// ===== src/cif_ifs.sv =====
interface cif_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             cmd;
    logic [cif_pkg::TAP_IDX_W-1:0]          tap_index;
    logic signed [cif_pkg::SAMPLE_W-1:0]    sample_re;
    logic signed [cif_pkg::SAMPLE_W-1:0]    sample_im;
    logic signed [cif_pkg::COEF_W-1:0]      coef_re;
    logic signed [cif_pkg::COEF_W-1:0]      coef_im;

    modport source (output valid, cmd, tap_index, sample_re, sample_im, coef_re, coef_im,
                    input ready);
    modport sink   (input valid, cmd, tap_index, sample_re, sample_im, coef_re, coef_im,
                    output ready);
endinterface

interface cif_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cif_pkg::SAMPLE_W-1:0]    out_re;
    logic signed [cif_pkg::SAMPLE_W-1:0]    out_im;
    logic                                   saturated;

    modport source (output valid, out_re, out_im, saturated, input ready);
    modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

interface cif_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [cif_pkg::CFG_IDX_W-1:0]          index;
    logic [cif_pkg::CFG_DATA_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/cif_mac.sv =====
module cif_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cif_pkg::t_mac_ctl               i_ctl,
    input  cif_pkg::t_smp                   i_x,
    input  cif_pkg::t_coef                  i_c,
    output logic                            o_busy,
    output logic signed [cif_pkg::ACC_W-1:0] o_acc_re,
    output logic signed [cif_pkg::ACC_W-1:0] o_acc_im
);

    logic                                   r_pv;
    logic signed [cif_pkg::PROD_W-1:0]      r_rr, r_ii, r_ri, r_ir;
    logic signed [cif_pkg::ACC_W-1:0]       r_acc_re, r_acc_im;
    logic signed [cif_pkg::ACC_W-1:0]       n_acc_re, n_acc_im;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rr <= i_x.re * i_c.re;
            r_ii <= i_x.im * i_c.im;
            r_ri <= i_x.re * i_c.im;
            r_ir <= i_x.im * i_c.re;
        end
    end

    // accumulate stage
    always_comb begin
        n_acc_re = r_acc_re + cif_pkg::ACC_W'(r_rr) - cif_pkg::ACC_W'(r_ii);
        n_acc_im = r_acc_im + cif_pkg::ACC_W'(r_ri) + cif_pkg::ACC_W'(r_ir);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_pv) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    assign o_busy   = r_pv;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// ===== src/complex_iir_filter.sv =====
// Channel | Dir | Payload                                         | Accepted when
// i_in    | in  | cmd, tap_index, sample_re/im, coef_re/im        | valid & ready
// o_out   | out | out_re, out_im, saturated                       | valid & ready
// i_cfg   | in  | index (0 ff_taps, 1 fb_taps), data              | valid & ready
//
// A sample item holds the block from its accept cycle until its result is loaded:
// one tap per cycle on the shared complex MAC, then the read and product stages drain,
// then ROUND loads the output register. With no taps at all the sample goes straight
// to DRAIN. Coefficient and clear items are taken in IDLE, which the block stays in.
// i_in.ready is high only in IDLE; rounding stalls while the output register stays full.
// Reset is synchronous, active low: tap counts go to 1 and 0, all tables read as zero.
module complex_iir_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cif_in_if.sink      i_in,
    cif_out_if.source   o_out,
    cif_cfg_if.sink     i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FF    = 5'b00010,
        S_FB    = 5'b00100,
        S_DRAIN = 5'b01000,
        S_ROUND = 5'b10000
    } t_state;

    localparam int IW = cif_pkg::TAP_IDX_W;
    localparam int CW = cif_pkg::TAP_CNT_W;
    localparam int QW = cif_pkg::ACC_W - cif_pkg::COEF_FRAC;

    typedef struct packed {
        logic signed [cif_pkg::SAMPLE_W-1:0] val;
        logic                                clip;
    } t_rsat;

    // round half up, dropping the 16 fraction bits of the Q2.16 coefficients, then clip to Q1.15
    function automatic t_rsat round_sat(input logic signed [cif_pkg::ACC_W-1:0] acc);
        logic signed [cif_pkg::ACC_W-1:0] t;
        logic signed [QW-1:0]             q;
        t_rsat                            r;
        t = acc + cif_pkg::ACC_W'(1 << (cif_pkg::COEF_FRAC - 1));
        q = t[cif_pkg::ACC_W-1:cif_pkg::COEF_FRAC];
        // fits when all bits from the sample sign bit up agree
        if ((&q[QW-1:cif_pkg::SAMPLE_W-1]) || !(|q[QW-1:cif_pkg::SAMPLE_W-1])) begin
            r.val  = q[cif_pkg::SAMPLE_W-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = q[QW-1] ? {1'b1, {(cif_pkg::SAMPLE_W-1){1'b0}}}
                             : {1'b0, {(cif_pkg::SAMPLE_W-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [CW-1:0] r_ff_taps, r_fb_taps;
    logic [CW-1:0] w_nff, w_nfb;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_taps <= CW'(1);
            r_fb_taps <= '0;
        end else if (i_cfg.valid) begin
            unique case (cif_pkg::t_reg_idx'(i_cfg.index))
                cif_pkg::REG_FF_TAPS: r_ff_taps <= i_cfg.data;
                cif_pkg::REG_FB_TAPS: r_fb_taps <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // counts above the table depth act as the full depth
    assign w_nff = (r_ff_taps > cif_pkg::MAX_TAP_CNT) ? cif_pkg::MAX_TAP_CNT : r_ff_taps;
    assign w_nfb = (r_fb_taps > cif_pkg::MAX_TAP_CNT) ? cif_pkg::MAX_TAP_CNT : r_fb_taps;

    // ---------------- sequencer ----------------
    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_in_head, n_in_head;
    logic [IW-1:0] r_out_head, n_out_head;

    logic          w_acc_in;
    cif_pkg::t_cmd w_cmd;
    logic          w_smp_wr, w_ffc_wr, w_fbc_wr, w_clear, w_issue, w_out_wr, w_load;
    logic          w_mac_busy;
    logic          w_cnt_last;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc_in   = i_in.valid && i_in.ready;
    assign w_cmd      = cif_pkg::t_cmd'(i_in.cmd);
    assign w_smp_wr   = w_acc_in && (w_cmd == cif_pkg::CMD_SAMPLE);
    assign w_ffc_wr   = w_acc_in && (w_cmd == cif_pkg::CMD_FF_COEF);
    assign w_fbc_wr   = w_acc_in && (w_cmd == cif_pkg::CMD_FB_COEF);
    assign w_clear    = w_acc_in && (w_cmd == cif_pkg::CMD_CLEAR);
    assign w_issue    = (r_state == S_FF) || (r_state == S_FB);
    assign w_cnt_last = ((r_cnt + CW'(1)) == ((r_state == S_FB) ? w_nfb : w_nff));

    logic r_out_valid;
    logic r_rd_v;

    // ROUND finishes once the output register is free
    assign w_load   = (r_state == S_ROUND) && (!r_out_valid || o_out.ready);
    assign w_out_wr = w_load && (w_nfb != '0);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_in_head  = r_in_head;
        n_out_head = r_out_head;
        unique case (r_state)
            S_IDLE: begin
                if (w_smp_wr) begin
                    n_in_head = r_in_head + IW'(1);
                    n_cnt     = '0;
                    if (w_nff != '0) begin
                        n_state = S_FF;
                    end else if (w_nfb != '0) begin
                        n_state = S_FB;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end else if (w_clear) begin
                    n_in_head  = '0;
                    n_out_head = '0;
                end
            end
            S_FF: begin
                if (w_cnt_last) begin
                    n_cnt   = '0;
                    n_state = (w_nfb != '0) ? S_FB : S_DRAIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_FB: begin
                if (w_cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DRAIN: begin
                // wait for read and product stages to empty
                if (!r_rd_v && !w_mac_busy) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (w_load) begin
                    n_state = S_IDLE;
                    if (w_out_wr) begin
                        n_out_head = r_out_head + IW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_head  <= '0;
            r_out_head <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_head  <= n_in_head;
            r_out_head <= n_out_head;
        end
    end

    // ---------------- storage ----------------
    // valid bits stand in for the zero reset of each table
    logic [cif_pkg::NUM_TAPS-1:0] r_ih_vld, r_oh_vld, r_ffc_vld, r_fbc_vld;

    cif_pkg::t_smp  r_ih_mem  [cif_pkg::NUM_TAPS];
    cif_pkg::t_smp  r_oh_mem  [cif_pkg::NUM_TAPS];
    cif_pkg::t_coef r_ffc_mem [cif_pkg::NUM_TAPS];
    cif_pkg::t_coef r_fbc_mem [cif_pkg::NUM_TAPS];

    cif_pkg::t_smp  r_ih_rd, r_oh_rd, w_smp_in, w_y;
    cif_pkg::t_coef r_ffc_rd, r_fbc_rd, w_coef_in;

    logic [IW-1:0] w_ih_addr, w_oh_addr, w_c_addr, w_oh_waddr;
    t_rsat         w_rs_re, w_rs_im;

    assign w_ih_addr  = r_in_head - r_cnt[IW-1:0];
    assign w_oh_addr  = r_out_head - r_cnt[IW-1:0];
    assign w_c_addr   = r_cnt[IW-1:0];
    assign w_oh_waddr = r_out_head + IW'(1);

    assign w_smp_in.re  = i_in.sample_re;
    assign w_smp_in.im  = i_in.sample_im;
    assign w_coef_in.re = i_in.coef_re;
    assign w_coef_in.im = i_in.coef_im;

    always_ff @(posedge i_clk) begin
        if (w_smp_wr) begin
            r_ih_mem[n_in_head] <= w_smp_in;
        end
        r_ih_rd <= r_ih_mem[w_ih_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_out_wr) begin
            r_oh_mem[w_oh_waddr] <= w_y;
        end
        r_oh_rd <= r_oh_mem[w_oh_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ffc_wr) begin
            r_ffc_mem[i_in.tap_index] <= w_coef_in;
        end
        r_ffc_rd <= r_ffc_mem[w_c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fbc_wr) begin
            r_fbc_mem[i_in.tap_index] <= w_coef_in;
        end
        r_fbc_rd <= r_fbc_mem[w_c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih_vld  <= '0;
            r_oh_vld  <= '0;
            r_ffc_vld <= '0;
            r_fbc_vld <= '0;
        end else begin
            if (w_clear) begin
                r_ih_vld <= '0;
                r_oh_vld <= '0;
            end
            if (w_smp_wr) begin
                r_ih_vld[n_in_head] <= 1'b1;
            end
            if (w_out_wr) begin
                r_oh_vld[w_oh_waddr] <= 1'b1;
            end
            if (w_ffc_wr) begin
                r_ffc_vld[i_in.tap_index] <= 1'b1;
            end
            if (w_fbc_wr) begin
                r_fbc_vld[i_in.tap_index] <= 1'b1;
            end
        end
    end

    // ---------------- read stage ----------------
    logic r_rd_sel;   // 1: feedback tap
    logic r_x_ok, r_c_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sel <= (r_state == S_FB);
        r_x_ok   <= (r_state == S_FB) ? r_oh_vld[w_oh_addr] : r_ih_vld[w_ih_addr];
        r_c_ok   <= (r_state == S_FB) ? r_fbc_vld[w_c_addr] : r_ffc_vld[w_c_addr];
    end

    cif_pkg::t_smp     w_mac_x;
    cif_pkg::t_coef    w_mac_c;
    cif_pkg::t_mac_ctl w_mac_ctl;
    logic signed [cif_pkg::ACC_W-1:0] w_acc_re, w_acc_im;

    // entries never written since reset (for the histories, since the last clear) read as zero
    assign w_mac_x = !r_x_ok ? '0 : (r_rd_sel ? r_oh_rd : r_ih_rd);
    assign w_mac_c = !r_c_ok ? '0 : (r_rd_sel ? r_fbc_rd : r_ffc_rd);

    assign w_mac_ctl.clr = w_smp_wr;
    assign w_mac_ctl.en  = r_rd_v;

    cif_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_x      (w_mac_x),
        .i_c      (w_mac_c),
        .o_busy   (w_mac_busy),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im)
    );

    // ---------------- rounding and output register ----------------
    assign w_rs_re = round_sat(w_acc_re);
    assign w_rs_im = round_sat(w_acc_im);
    assign w_y.re  = w_rs_re.val;
    assign w_y.im  = w_rs_im.val;

    logic signed [cif_pkg::SAMPLE_W-1:0] r_out_re, r_out_im;
    logic                                r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_re  <= w_y.re;
            r_out_im  <= w_y.im;
            r_out_sat <= w_rs_re.clip || w_rs_im.clip;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_re    = r_out_re;
    assign o_out.out_im    = r_out_im;
    assign o_out.saturated = r_out_sat;

endmodule

// ===== test/tb_complex_iir_filter.sv =====
`timescale 1ns / 100ps

module tb_complex_iir_filter;

    localparam int SMP_W = cif_pkg::SAMPLE_W;
    localparam int CF_W  = cif_pkg::COEF_W;
    localparam int FRAC  = cif_pkg::COEF_FRAC;
    localparam int DEPTH = cif_pkg::NUM_TAPS;
    localparam int IDX_W = cif_pkg::TAP_IDX_W;
    localparam int CNT_W = cif_pkg::TAP_CNT_W;
    localparam int DAT_W = cif_pkg::CFG_DATA_W;

    // Stop the random part once this many input items have been accepted.
    localparam int ITEM_GOAL = 1900;
    // Idle tails for settle(): short between settings, longer at the end of the run.
    localparam int SHORT_TAIL = 8;
    localparam int END_TAIL   = 80;

    localparam longint SMP_MAX = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    // One input item as the block sees it.
    typedef struct {
        cif_pkg::t_cmd          cmd;
        logic [IDX_W-1:0]       idx;
        cif_pkg::t_smp          smp;
        cif_pkg::t_coef         coef;
    } t_filt_item;

    // One filter output: both parts plus the clip flag.
    typedef struct {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        logic                    sat;
    } t_filt_out;

    // Shadow of the filter: tables, histories and tap counts, kept in step with
    // every accepted item and register write. Outputs it predicts wait in
    // expected_out until the block delivers them.
    class iir_track;
        cif_pkg::t_smp          in_hist [DEPTH];
        cif_pkg::t_smp          out_hist[DEPTH];
        cif_pkg::t_coef         ff_tab  [DEPTH];
        cif_pkg::t_coef         fb_tab  [DEPTH];
        logic [IDX_W-1:0]       in_head;
        logic [IDX_W-1:0]       out_head;
        logic [CNT_W-1:0]       ff_cnt;
        logic [CNT_W-1:0]       fb_cnt;
        t_filt_out              expected_out[$];
        int                     n_bad;

        function new();
            clear_hist();
            foreach (ff_tab[i]) begin
                ff_tab[i] = '0;
                fb_tab[i] = '0;
            end
            ff_cnt = CNT_W'(1);
            fb_cnt = '0;
            n_bad  = 0;
        endfunction

        function void clear_hist();
            foreach (in_hist[i]) begin
                in_hist[i]  = '0;
                out_hist[i] = '0;
            end
            in_head  = '0;
            out_head = '0;
        endfunction

        function void set_reg(cif_pkg::t_reg_idx r, logic [DAT_W-1:0] v);
            if (r == cif_pkg::REG_FF_TAPS) begin
                ff_cnt = v;
            end else begin
                fb_cnt = v;
            end
        endfunction

        // Exact complex multiply-accumulate.
        function void cmac(inout longint ar, inout longint ai, input cif_pkg::t_smp x,
                           input cif_pkg::t_coef c);
            ar += longint'($signed(x.re)) * longint'($signed(c.re))
                - longint'($signed(x.im)) * longint'($signed(c.im));
            ai += longint'($signed(x.re)) * longint'($signed(c.im))
                + longint'($signed(x.im)) * longint'($signed(c.re));
        endfunction

        // Round to nearest (ties up) from Q.16 and clip to the sample range.
        function logic signed [SMP_W-1:0] round_sat(longint a, inout logic clip);
            longint r;
            r = (a + (longint'(1) << (FRAC - 1))) >>> FRAC;
            if (r > SMP_MAX) begin
                clip = 1'b1;
                return SMP_W'(SMP_MAX);
            end
            if (r < SMP_MIN) begin
                clip = 1'b1;
                return SMP_W'(SMP_MIN);
            end
            return SMP_W'(r);
        endfunction

        function t_filt_out filter_sample(cif_pkg::t_smp x);
            longint     acc_re;
            longint     acc_im;
            int         nff;
            int         nfb;
            logic       clip;
            t_filt_out  y;
            in_head          = in_head + 1'b1;
            in_hist[in_head] = x;
            // counts above the table depth act as the full depth
            nff    = (ff_cnt > DEPTH) ? DEPTH : int'(ff_cnt);
            nfb    = (fb_cnt > DEPTH) ? DEPTH : int'(fb_cnt);
            acc_re = 0;
            acc_im = 0;
            for (int i = 0; i < nff; i++) begin
                cmac(acc_re, acc_im, in_hist[IDX_W'(in_head - i)], ff_tab[i]);
            end
            // feedback is added, newest output first
            for (int i = 0; i < nfb; i++) begin
                cmac(acc_re, acc_im, out_hist[IDX_W'(out_head - i)], fb_tab[i]);
            end
            clip  = 1'b0;
            y.re  = round_sat(acc_re, clip);
            y.im  = round_sat(acc_im, clip);
            y.sat = clip;
            // pure FIR leaves the output history alone
            if (nfb > 0) begin
                out_head           = out_head + 1'b1;
                out_hist[out_head] = '{re: y.re, im: y.im};
            end
            return y;
        endfunction

        function void take_item(t_filt_item it);
            unique case (it.cmd)
                cif_pkg::CMD_FF_COEF: ff_tab[it.idx] = it.coef;
                cif_pkg::CMD_FB_COEF: fb_tab[it.idx] = it.coef;
                cif_pkg::CMD_CLEAR:   clear_hist();
                default:              expected_out.push_back(filter_sample(it.smp));
            endcase
        endfunction

        function void take_output(logic signed [SMP_W-1:0] re,
                                  logic signed [SMP_W-1:0] im, logic sat);
            t_filt_out e;
            if (expected_out.size() == 0) begin
                n_bad++;
                $display("%0t: output with none expected: re=%0d im=%0d sat=%0b",
                         $time, re, im, sat);
                return;
            end
            e = expected_out.pop_front();
            if (e.re !== re || e.im !== im || e.sat !== sat) begin
                n_bad++;
                $display("%0t: output mismatch: expected re=%0d im=%0d sat=%0b,",
                         $time, e.re, e.im, e.sat);
                $display("    got re=%0d im=%0d sat=%0b", re, im, sat);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cif_in_if  in_ch();
    cif_out_if out_ch();
    cif_cfg_if cfg_ch();

    complex_iir_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    iir_track track = new();

    int n_sent;
    int in_idle_pct;
    int out_idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random field values: full range about a third of the time, otherwise
    // scaled down so that the filter spends time away from the clip limits.
    function automatic logic [SMP_W-1:0] rnd_smp();
        logic signed [SMP_W-1:0] v;
        v = SMP_W'($urandom);
        if ($urandom_range(2) != 0) begin
            v = v >>> $urandom_range(1, 8);
        end
        return v;
    endfunction

    function automatic logic [CF_W-1:0] rnd_coef();
        logic signed [CF_W-1:0] v;
        v = CF_W'($urandom);
        if ($urandom_range(2) != 0) begin
            v = v >>> $urandom_range(1, 12);
        end
        return v;
    endfunction

    // Tap counts: extremes, small filters, and anything the 6-bit field holds.
    function automatic logic [DAT_W-1:0] pick_taps();
        unique case ($urandom_range(7))
            0:       return DAT_W'(0);
            1:       return DAT_W'(1);
            2:       return DAT_W'(DEPTH);
            3:       return '1;
            4:       return DAT_W'($urandom_range(1, 4));
            default: return DAT_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Offer one item; valid stays up after acceptance so back-to-back items
    // never drop it. The idle mix shifts with progress through the run.
    task automatic put_item(cif_pkg::t_cmd c, logic [IDX_W-1:0] idx,
                            logic [SMP_W-1:0] sre, logic [SMP_W-1:0] sim,
                            logic [CF_W-1:0] cre, logic [CF_W-1:0] cim);
        t_filt_item it;
        if (n_sent < ITEM_GOAL / 3) begin
            in_idle_pct  = 15;
            out_idle_pct = 79;
        end else if (n_sent < 2 * ITEM_GOAL / 3) begin
            in_idle_pct  = 79;
            out_idle_pct = 15;
        end else begin
            in_idle_pct  = 0;
            out_idle_pct = 0;
        end
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.tap_index <= idx;
        in_ch.sample_re <= sre;
        in_ch.sample_im <= sim;
        in_ch.coef_re   <= cre;
        in_ch.coef_im   <= cim;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        it.cmd     = c;
        it.idx     = idx;
        it.smp.re  = sre;
        it.smp.im  = sim;
        it.coef.re = cre;
        it.coef.im = cim;
        track.take_item(it);
        n_sent++;
    endtask

    task automatic write_reg(cif_pkg::t_reg_idx r, logic [DAT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        track.set_reg(r, v);
    endtask

    task automatic set_taps(logic [DAT_W-1:0] ff, logic [DAT_W-1:0] fb);
        write_reg(cif_pkg::REG_FF_TAPS, ff);
        write_reg(cif_pkg::REG_FB_TAPS, fb);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold off the sender until every predicted output is back, then give
    // a coefficient or clear item still in flight time to land.
    task automatic settle(int tail);
        in_ch.valid <= 1'b0;
        while (track.expected_out.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Output side: check on each handshake, then pick ready for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            track.take_output(out_ch.out_re, out_ch.out_im, out_ch.saturated);
        end
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    initial begin
        int nff;
        int nfb;
        int n_smp;
        int r;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = cif_pkg::CMD_SAMPLE;
        in_ch.tap_index = '0;
        in_ch.sample_re = '0;
        in_ch.sample_im = '0;
        in_ch.coef_re   = '0;
        in_ch.coef_im   = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = cif_pkg::REG_FF_TAPS;
        cfg_ch.data     = '0;
        n_sent          = 0;
        in_idle_pct     = 15;
        out_idle_pct    = 79;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // Reset state: one ff tap, no feedback, all tables zero.
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h0000, 16'h0000, 18'h00000, 18'h00000);
        // Unity tap passes the extremes through untouched.
        put_item(cif_pkg::CMD_FF_COEF, 5'd0, rnd_smp(), rnd_smp(), 18'h10000, 18'h00000);
        put_item(cif_pkg::CMD_SAMPLE, 5'd3, 16'h7fff, 16'h8000, rnd_coef(), rnd_coef());
        // Largest coefficient on largest sample: real part cancels, imag clips high.
        put_item(cif_pkg::CMD_FF_COEF, 5'd0, rnd_smp(), rnd_smp(), 18'h1ffff, 18'h1ffff);
        put_item(cif_pkg::CMD_SAMPLE, 5'd31, 16'h7fff, 16'h7fff, rnd_coef(), rnd_coef());
        // Most negative on most negative: imag clips high again.
        put_item(cif_pkg::CMD_FF_COEF, 5'd0, rnd_smp(), rnd_smp(), 18'h20000, 18'h20000);
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h8000, 16'h8000, rnd_coef(), rnd_coef());
        // One half times one LSB: exact half ties, one goes up and one lands on zero.
        put_item(cif_pkg::CMD_FF_COEF, 5'd0, rnd_smp(), rnd_smp(), 18'h08000, 18'h00000);
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h0001, 16'hffff, rnd_coef(), rnd_coef());
        // Top table entries, then a feedback tap for later.
        put_item(cif_pkg::CMD_FF_COEF, 5'd31, rnd_smp(), rnd_smp(), 18'h00001, 18'h3ffff);
        put_item(cif_pkg::CMD_FB_COEF, 5'd31, rnd_smp(), rnd_smp(), 18'h3ffff, 18'h00001);
        put_item(cif_pkg::CMD_FB_COEF, 5'd0, rnd_smp(), rnd_smp(), 18'h08000, 18'h38000);
        put_item(cif_pkg::CMD_CLEAR, 5'd7, rnd_smp(), rnd_smp(), rnd_coef(), rnd_coef());

        // No ff taps at all, fb count past the table depth.
        settle(SHORT_TAIL);
        set_taps(6'd0, 6'd63);
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h0064, 16'hff9c, rnd_coef(), rnd_coef());
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, rnd_smp(), rnd_smp(), rnd_coef(), rnd_coef());

        // ff count past the depth, single feedback tap; histories carry over.
        settle(SHORT_TAIL);
        set_taps(6'd63, 6'd1);
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h7fff, 16'h7fff, rnd_coef(), rnd_coef());
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h8000, 16'h0000, rnd_coef(), rnd_coef());
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'h3039, 16'he57b, rnd_coef(), rnd_coef());
        put_item(cif_pkg::CMD_CLEAR, 5'd0, rnd_smp(), rnd_smp(), rnd_coef(), rnd_coef());
        put_item(cif_pkg::CMD_SAMPLE, 5'd0, 16'hffff, 16'h0001, rnd_coef(), rnd_coef());

        // Both tables at full depth.
        settle(SHORT_TAIL);
        set_taps(6'd32, 6'd32);
        repeat (3) begin
            put_item(cif_pkg::CMD_SAMPLE, 5'(($urandom)), 16'($urandom), 16'($urandom),
                     rnd_coef(), rnd_coef());
        end

        // ---- random part ----
        // Each pass is one filter setting: new tap counts, coefficients for
        // the taps in use, then a sample stream with some noise mixed in.
        while (n_sent < ITEM_GOAL) begin
            settle(SHORT_TAIL);
            set_taps(pick_taps(), pick_taps());
            nff = (track.ff_cnt > DEPTH) ? DEPTH : int'(track.ff_cnt);
            nfb = (track.fb_cnt > DEPTH) ? DEPTH : int'(track.fb_cnt);
            if ($urandom_range(1) != 0) begin
                put_item(cif_pkg::CMD_CLEAR, 5'($urandom), rnd_smp(), rnd_smp(),
                         rnd_coef(), rnd_coef());
            end
            // Refresh a handful of the in-use taps; the rest keep old values.
            for (int i = 0; i < nff; i++) begin
                if (i < 2 || $urandom_range(nff - 1) < 5) begin
                    put_item(cif_pkg::CMD_FF_COEF, 5'(i), rnd_smp(), rnd_smp(),
                             rnd_coef(), rnd_coef());
                end
            end
            for (int i = 0; i < nfb; i++) begin
                if (i < 2 || $urandom_range(nfb - 1) < 5) begin
                    put_item(cif_pkg::CMD_FB_COEF, 5'(i), rnd_smp(), rnd_smp(),
                             rnd_coef(), rnd_coef());
                end
            end
            n_smp = $urandom_range(8, 60);
            repeat (n_smp) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    // stray coefficient write anywhere in either table
                    put_item($urandom_range(1) ? cif_pkg::CMD_FF_COEF : cif_pkg::CMD_FB_COEF,
                             5'($urandom), rnd_smp(), rnd_smp(), rnd_coef(), rnd_coef());
                end else if (r < 6) begin
                    put_item(cif_pkg::CMD_CLEAR, 5'($urandom), rnd_smp(), rnd_smp(),
                             rnd_coef(), rnd_coef());
                end else if (r < 8) begin
                    // sender holds off until the block has drained
                    settle(0);
                end else begin
                    put_item(cif_pkg::CMD_SAMPLE, 5'($urandom), rnd_smp(), rnd_smp(),
                             rnd_coef(), rnd_coef());
                end
            end
        end

        settle(END_TAIL);
        if (track.n_bad == 0 && track.expected_out.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop, several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/cif_pkg.sv
src/cif_ifs.sv
src/cif_mac.sv
src/complex_iir_filter.sv
test/tb_complex_iir_filter.sv
